@@ hdl/b2d_pkg.sv @@
// package for the binary to decimal ascii converter
// shared constants and the cell control struct; no dependencies

package b2d_pkg;

    localparam int DEF_VALUE_WIDTH = 64;
    localparam int DEF_MAX_DIGITS  = 20;

    localparam int IN_BITS         = 64;
    localparam int DIGIT_BITS      = 4;
    localparam int CHAR_BITS       = 6;
    localparam int OUT_TDATA_BITS  = 8;

    localparam logic [DIGIT_BITS-1:0] ADJ_LIMIT = 4'd5;
    localparam logic [DIGIT_BITS-1:0] ADJ_ADD   = 4'd3;
    localparam logic [CHAR_BITS-1:0]  ASCII_ZERO = 6'd48;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic dshift;
    } cell_ctrl_t;

endpackage

@@ hdl/b2d_cell.sv @@
// one bcd digit cell of the shift-add-3 chain
// depends on b2d_pkg for the control struct and digit constants

module b2d_cell (
    input  logic                          aclk,
    input  b2d_pkg::cell_ctrl_t           ctrl,
    input  logic                          bit_in,
    input  logic [b2d_pkg::DIGIT_BITS-1:0] digit_in,
    output logic                          bit_out,
    output logic [b2d_pkg::DIGIT_BITS-1:0] digit
);
    import b2d_pkg::*;

    logic [DIGIT_BITS-1:0] digit_reg;
    logic [DIGIT_BITS-1:0] digit_next;
    logic [DIGIT_BITS-1:0] adj;

    // add 3 to digits of 5 or more before the shift
    assign adj     = (digit_reg >= ADJ_LIMIT) ? digit_reg + ADJ_ADD : digit_reg;
    assign bit_out = adj[DIGIT_BITS-1];
    assign digit   = digit_reg;

    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = '0;
        end else if (ctrl.dabble) begin
            digit_next = {adj[DIGIT_BITS-2:0], bit_in};
        end else if (ctrl.dshift) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

endmodule

@@ hdl/binary_to_decimal_ascii.sv @@
// top level of the binary to decimal ascii converter
// depends on b2d_pkg and b2d_cell
//
//  channel | ports                      | transaction
//  --------+----------------------------+---------------------------------------
//  input   | s_tvalid s_tready s_tdata  | one unsigned binary value
//  output  | m_tvalid m_tready m_tdata  | one ascii digit, msd first, tlast on
//          | m_tlast                    | the least significant digit
//
// an input transaction for an n digit result goes through three phases: the input
// bits enter the chain of digit cells one per cycle, msb first, by the shift-add-3 step;
// then leading zeros are skipped one per cycle, and the characters are sent one per
// cycle while the output side does not stall, both by the digit shift of the chain
// reset (aresetn low, synchronous) returns the controller to idle
// an output stall simply holds the chain; a new value is taken only in idle

module binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = b2d_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_DIGITS  = b2d_pkg::DEF_MAX_DIGITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [b2d_pkg::IN_BITS-1:0]        s_tdata,   // [63:0] value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [b2d_pkg::OUT_TDATA_BITS-1:0] m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                              m_tlast    // last_char
);
    import b2d_pkg::*;

    localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;

    cell_ctrl_t             ctrl;
    logic [DIGIT_BITS-1:0]  cell_digit [MAX_DIGITS];
    logic                   cell_carry [MAX_DIGITS];
    logic [DIGIT_BITS-1:0]  top_digit;
    logic                   in_xfer;
    logic                   out_xfer;

    assign top_digit = cell_digit[MAX_DIGITS-1];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign m_tvalid  = (state_reg == ST_EMIT);
    assign out_xfer  = m_tvalid && m_tready;

    // character from the most significant cell
    assign m_tdata = {{(OUT_TDATA_BITS - CHAR_BITS){1'b0}},
                      ASCII_ZERO + {{(CHAR_BITS - DIGIT_BITS){1'b0}}, top_digit}};
    assign m_tlast = (dig_cnt_reg == DIG_CNT_W'(1));

    // the chain: bits ripple up one cell per step during conversion,
    // whole digits move up one cell per step while skipping or sending
    for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
        logic                  bit_in;
        logic [DIGIT_BITS-1:0] digit_in;
        if (i == 0) begin : g_first
            assign bit_in   = value_reg[VALUE_WIDTH-1];
            assign digit_in = '0;
        end else begin : g_rest
            assign bit_in   = cell_carry[i-1];
            assign digit_in = cell_digit[i-1];
        end
        b2d_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .bit_in   (bit_in),
            .digit_in (digit_in),
            .bit_out  (cell_carry[i]),
            .digit    (cell_digit[i])
        );
    end

    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        ctrl         = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    ctrl.clear   = 1'b1;
                    value_next   = s_tdata[VALUE_WIDTH-1:0];
                    bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH - 1);
                    dig_cnt_next = DIG_CNT_W'(MAX_DIGITS);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                // one input bit per cycle, msb first
                ctrl.dabble  = 1'b1;
                value_next   = {value_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == '0) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, the units digit always goes out
                if (top_digit == '0 && dig_cnt_reg > DIG_CNT_W'(1)) begin
                    ctrl.dshift  = 1'b1;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_xfer) begin
                    ctrl.dshift  = 1'b1;
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                    if (dig_cnt_reg == DIG_CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        value_reg   <= value_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
    end

endmodule
